>>> rtl/rvde_pkg.sv
// Shared types and constants for the RV32IM decode/execute pipeline.
// No dependencies.
`timescale 1ns / 1ps

package rvde_pkg;

  localparam logic [6:0] OPC_LOAD    = 7'd3;
  localparam logic [6:0] OPC_OPIMM   = 7'd19;
  localparam logic [6:0] OPC_OPIMM32 = 7'd27;
  localparam logic [6:0] OPC_JALR    = 7'd103;
  localparam logic [6:0] OPC_AUIPC   = 7'd23;
  localparam logic [6:0] OPC_LUI     = 7'd55;
  localparam logic [6:0] OPC_STORE   = 7'd35;
  localparam logic [6:0] OPC_OP      = 7'd51;
  localparam logic [6:0] OPC_OP32    = 7'd59;
  localparam logic [6:0] OPC_BRANCH  = 7'd99;
  localparam logic [6:0] OPC_JAL     = 7'd111;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  localparam logic [2:0] LK_NONE = 3'd0;
  localparam logic [1:0] SS_NONE = 2'd0;

  // divider: DivBits quotient bits per stage
  localparam int DivBits   = 4;
  localparam int DivStages = 32 / DivBits;

  typedef enum logic [3:0] {
    CL_BAD, CL_LOAD, CL_STORE, CL_OPIMM, CL_OP, CL_MUL, CL_DIV,
    CL_AUIPC, CL_LUI, CL_JAL, CL_JALR, CL_BRANCH
  } cls_e;

  typedef enum logic [1:0] { M_NONE, M_MUL, M_DIV } mcls_e;

  typedef struct packed {
    cls_e        cls;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic        alt;
    logic [31:0] imm;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] pc;
  } dec_t;

  typedef struct packed {
    logic [4:0]  dest_reg;
    logic        dest_write;
    logic [31:0] val;
    logic [31:0] next_pc;
    logic [2:0]  load_kind;
    logic [1:0]  store_size;
    logic [31:0] mem_address;
    logic [31:0] store_value;
    logic        bad;
    mcls_e       mcls;
    logic [2:0]  f3;
    logic        neg_q;
    logic        neg_r;
    logic        div0;
    logic [31:0] dvd;
    logic [63:0] prod;
  } res_t;

endpackage

>>> rtl/rvde_if.sv
// Valid/ready channel interfaces for instruction requests and results.
// Depends on nothing.
`timescale 1ns / 1ps

interface rvde_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        instruction;
  logic [31:0]        pc;
  logic signed [31:0] rs1_value;
  logic signed [31:0] rs2_value;
  modport source (output valid, instruction, pc, rs1_value, rs2_value, input ready);
  modport sink   (input valid, instruction, pc, rs1_value, rs2_value, output ready);
endinterface

interface rvde_out_if;
  logic               valid;
  logic               ready;
  logic [4:0]         dest_reg;
  logic               dest_write;
  logic signed [31:0] dest_value;
  logic [31:0]        next_pc;
  logic [2:0]         load_kind;
  logic [1:0]         store_size;
  logic [31:0]        mem_address;
  logic signed [31:0] store_value;
  logic               unknown_instruction;
  modport source (output valid, dest_reg, dest_write, dest_value, next_pc, load_kind,
                  store_size, mem_address, store_value, unknown_instruction, input ready);
  modport sink   (input valid, dest_reg, dest_write, dest_value, next_pc, load_kind,
                  store_size, mem_address, store_value, unknown_instruction, output ready);
endinterface

>>> rtl/rv32im_decode_execute.sv
// RV32IM decode/execute pipeline: decode, execute, divider stages, final select.
// Each request passes the decode, execute, divider-stage and output registers; one request per cycle unless held.
// The pipeline moves as a whole; it holds while a result waits and out ready is low.
// Reset (rst_ni low, asynchronous) clears all valid bits; payload is not reset.
// Depends on rvde_pkg, rvde_if and rvde_div.
`timescale 1ns / 1ps

module rv32im_decode_execute import rvde_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  rvde_in_if.sink       req_i,
  rvde_out_if.source    rsp_o
);

  logic adv;
  logic va_q;
  dec_t da_d, da_q;
  logic vb_q;
  res_t rb_d, rb_q;
  logic [31:0] dvd_d, dvd_q, dvs_d, dvs_q;
  logic [DivStages-1:0] vs_q;
  res_t rs_q [DivStages];
  logic [31:0] quo, rem;
  res_t fin;
  logic [31:0] fin_val;
  res_t fin_res;
  logic vo_q;
  res_t ro_q;

  assign adv = !vo_q || rsp_o.ready;
  assign req_i.ready = adv;

  // ---------------- decode ----------------
  always_comb begin
    logic [31:0] ins;
    logic [6:0]  opc, f7;
    logic [2:0]  f3;
    logic        bad;
    ins = req_i.instruction;
    opc = ins[6:0];
    f3  = ins[14:12];
    f7  = ins[31:25];
    bad = 1'b0;
    da_d.cls = CL_BAD;
    da_d.rd  = ins[11:7];
    da_d.f3  = f3;
    da_d.alt = 1'b0;
    da_d.imm = {{20{ins[31]}}, ins[31:20]};
    da_d.a   = req_i.rs1_value;
    da_d.b   = req_i.rs2_value;
    da_d.pc  = req_i.pc;
    unique case (opc)
      OPC_LOAD: begin
        bad = (f3 == 3'd3) || (f3 > 3'd5);
        da_d.cls = CL_LOAD;
      end
      OPC_STORE: begin
        bad = f3 > 3'd2;
        da_d.cls = CL_STORE;
        da_d.imm = {{20{ins[31]}}, ins[31:25], ins[11:7]};
      end
      OPC_OPIMM, OPC_OPIMM32: begin
        if (opc == OPC_OPIMM32 && f3 != 3'd0 && f3 != 3'd1 && f3 != 3'd5) bad = 1'b1;
        if (f3 == 3'd1 && f7 != F7_BASE) bad = 1'b1;
        if (f3 == 3'd5 && f7 != F7_BASE && f7 != F7_ALT) bad = 1'b1;
        da_d.cls = CL_OPIMM;
        da_d.alt = (f3 == 3'd5) && (f7 == F7_ALT);
      end
      OPC_OP, OPC_OP32: begin
        if (f7 == F7_MULDIV) begin
          if (opc == OPC_OP32 && f3 >= 3'd1 && f3 <= 3'd3) bad = 1'b1;
          da_d.cls = f3[2] ? CL_DIV : CL_MUL;
        end else if (f7 == F7_BASE || f7 == F7_ALT) begin
          if (f7 == F7_ALT && f3 != 3'd0 && f3 != 3'd5) bad = 1'b1;
          if (opc == OPC_OP32 && f3 != 3'd0 && f3 != 3'd1 && f3 != 3'd5) bad = 1'b1;
          da_d.cls = CL_OP;
          da_d.alt = f7 == F7_ALT;
        end else begin
          bad = 1'b1;
        end
      end
      OPC_AUIPC: begin
        da_d.cls = CL_AUIPC;
        da_d.imm = {ins[31:12], 12'd0};
      end
      OPC_LUI: begin
        da_d.cls = CL_LUI;
        da_d.imm = {ins[31:12], 12'd0};
      end
      OPC_JAL: begin
        da_d.cls = CL_JAL;
        da_d.imm = {{12{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
      end
      OPC_JALR: begin
        bad = f3 != 3'd0;
        da_d.cls = CL_JALR;
      end
      OPC_BRANCH: begin
        bad = (f3 == 3'd2) || (f3 == 3'd3);
        da_d.cls = CL_BRANCH;
        da_d.imm = {{20{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
      end
      default: bad = 1'b1;
    endcase
    if (bad) da_d.cls = CL_BAD;
  end

  // ---------------- execute ----------------
  function automatic logic [31:0] base_op(input logic [2:0] f3, input logic alt,
                                          input logic [31:0] a, input logic [31:0] b);
    logic [4:0] sh;
    sh = b[4:0];
    case (f3)
      3'd0:    return alt ? a - b : a + b;
      3'd1:    return a << sh;
      3'd2:    return {31'd0, $signed(a) < $signed(b)};
      3'd3:    return {31'd0, a < b};
      3'd4:    return a ^ b;
      3'd5:    return alt ? 32'($signed(a) >>> sh) : a >> sh;
      3'd6:    return a | b;
      default: return a & b;
    endcase
  endfunction

  always_comb begin
    logic [31:0] seq, sum;
    logic        take, sgn_a, sgn_b, div_s;
    logic signed [32:0] ax, bx;
    logic signed [65:0] p;
    seq = da_q.pc + 32'd4;
    sum = da_q.a + da_q.imm;
    case (da_q.f3)
      3'd0:    take = da_q.a == da_q.b;
      3'd1:    take = da_q.a != da_q.b;
      3'd4:    take = $signed(da_q.a) < $signed(da_q.b);
      3'd5:    take = $signed(da_q.a) >= $signed(da_q.b);
      3'd6:    take = da_q.a < da_q.b;
      default: take = da_q.a >= da_q.b;
    endcase
    rb_d = '0;
    rb_d.next_pc = seq;
    rb_d.f3      = da_q.f3;
    rb_d.mcls    = M_NONE;
    rb_d.dvd     = da_q.a;
    rb_d.dest_reg = da_q.rd;
    rb_d.dest_write = 1'b1;
    unique case (da_q.cls)
      CL_LOAD: begin
        rb_d.load_kind   = (da_q.f3 < 3'd3) ? da_q.f3 + 3'd1 : da_q.f3;
        rb_d.mem_address = sum;
      end
      CL_STORE: begin
        rb_d.dest_write  = 1'b0;
        rb_d.store_size  = da_q.f3[1:0] + 2'd1;
        rb_d.mem_address = sum;
        rb_d.store_value = da_q.b;
      end
      CL_OPIMM:  rb_d.val = base_op(da_q.f3, da_q.alt, da_q.a, da_q.imm);
      CL_OP:     rb_d.val = base_op(da_q.f3, da_q.alt, da_q.a, da_q.b);
      CL_MUL:    rb_d.mcls = M_MUL;
      CL_DIV:    rb_d.mcls = M_DIV;
      CL_AUIPC:  rb_d.val = da_q.pc + da_q.imm;
      CL_LUI:    rb_d.val = da_q.imm;
      CL_JAL: begin
        rb_d.val     = seq;
        rb_d.next_pc = da_q.pc + da_q.imm;
      end
      CL_JALR: begin
        rb_d.val     = seq;
        rb_d.next_pc = {sum[31:1], 1'b0};
      end
      CL_BRANCH: begin
        rb_d.dest_write = 1'b0;
        if (take) rb_d.next_pc = da_q.pc + da_q.imm;
      end
      default: begin
        rb_d.dest_write = 1'b0;
        rb_d.bad = 1'b1;
      end
    endcase
    if (!rb_d.dest_write) rb_d.dest_reg = '0;

    // multiply: signedness per mulh / mulhsu / mulhu
    ax = {(da_q.f3 != 3'd3) & da_q.a[31], da_q.a};
    bx = {(da_q.f3 == 3'd1) & da_q.b[31], da_q.b};
    p  = ax * bx;
    rb_d.prod = p[63:0];

    // divide operands: magnitudes for signed forms
    div_s = !da_q.f3[0];
    sgn_a = div_s & da_q.a[31];
    sgn_b = div_s & da_q.b[31];
    dvd_d = sgn_a ? 32'd0 - da_q.a : da_q.a;
    dvs_d = sgn_b ? 32'd0 - da_q.b : da_q.b;
    rb_d.neg_q = sgn_a ^ sgn_b;
    rb_d.neg_r = sgn_a;
    rb_d.div0  = da_q.b == 32'd0;
  end

  rvde_div u_div (
    .clk_i       (clk_i),
    .en_i        (adv),
    .dividend_i  (dvd_q),
    .divisor_i   (dvs_q),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  // ---------------- final select ----------------
  assign fin = rs_q[DivStages-1];

  always_comb begin
    fin_val = fin.val;
    case (fin.mcls)
      M_MUL: fin_val = (fin.f3[1:0] == 2'd0) ? fin.prod[31:0] : fin.prod[63:32];
      M_DIV: begin
        if (!fin.f3[1]) begin
          if (fin.div0) fin_val = '1;
          else          fin_val = fin.neg_q ? 32'd0 - quo : quo;
        end else begin
          if (fin.div0) fin_val = fin.dvd;
          else          fin_val = fin.neg_r ? 32'd0 - rem : rem;
        end
      end
      default: fin_val = fin.val;
    endcase
    fin_res     = fin;
    fin_res.val = fin_val;
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vs_q <= '0;
      vo_q <= 1'b0;
    end else if (adv) begin
      va_q <= req_i.valid;
      vb_q <= va_q;
      vs_q <= {vs_q[DivStages-2:0], vb_q};
      vo_q <= vs_q[DivStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      da_q  <= da_d;
      rb_q  <= rb_d;
      dvd_q <= dvd_d;
      dvs_q <= dvs_d;
      rs_q[0] <= rb_q;
      for (int i = 1; i < DivStages; i++) rs_q[i] <= rs_q[i-1];
      ro_q  <= fin_res;
    end
  end

  assign rsp_o.valid               = vo_q;
  assign rsp_o.dest_reg            = ro_q.dest_reg;
  assign rsp_o.dest_write          = ro_q.dest_write;
  assign rsp_o.dest_value          = ro_q.val;
  assign rsp_o.next_pc             = ro_q.next_pc;
  assign rsp_o.load_kind           = ro_q.load_kind;
  assign rsp_o.store_size          = ro_q.store_size;
  assign rsp_o.mem_address         = ro_q.mem_address;
  assign rsp_o.store_value         = ro_q.store_value;
  assign rsp_o.unknown_instruction = ro_q.bad;

  // ---------------- assertions ----------------
  a_bad_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q && ro_q.bad |-> !ro_q.dest_write && ro_q.store_size == SS_NONE)
    else $error("unknown instruction carries side effects");
  a_load_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q && ro_q.load_kind != LK_NONE |-> ro_q.val == 32'd0 && ro_q.dest_write)
    else $error("load result carries a value");
  a_store_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q && ro_q.store_size != SS_NONE |-> !ro_q.dest_write && ro_q.dest_reg == 5'd0)
    else $error("store writes a register");
  a_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> va_q == $past(req_i.valid))
    else $error("request lost at pipeline entry");

endmodule

>>> rtl/rvde_div.sv
// Pipelined unsigned restoring divider, DivBits quotient bits per stage.
// Depends on rvde_pkg.
`timescale 1ns / 1ps

module rvde_div import rvde_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic [31:0] quotient_o,
  output logic [31:0] remainder_o
);

  logic [31:0] r_q [DivStages];
  logic [31:0] q_q [DivStages];
  logic [31:0] d_q [DivStages];

  function automatic logic [63:0] steps(input logic [31:0] r, input logic [31:0] q,
                                        input logic [31:0] d);
    logic [32:0] t;
    logic [31:0] rr;
    logic [31:0] qq;
    rr = r;
    qq = q;
    for (int i = 0; i < DivBits; i++) begin
      t = {rr, qq[31]};
      if (t >= {1'b0, d}) begin
        rr = 32'(t - {1'b0, d});
        qq = {qq[30:0], 1'b1};
      end else begin
        rr = t[31:0];
        qq = {qq[30:0], 1'b0};
      end
    end
    return {rr, qq};
  endfunction

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic [31:0] r_in, q_in, d_in;
    logic [63:0] nxt;
    if (s == 0) begin : g_first
      assign r_in = '0;
      assign q_in = dividend_i;
      assign d_in = divisor_i;
    end else begin : g_rest
      assign r_in = r_q[s-1];
      assign q_in = q_q[s-1];
      assign d_in = d_q[s-1];
    end
    assign nxt = steps(r_in, q_in, d_in);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s] <= nxt[63:32];
        q_q[s] <= nxt[31:0];
        d_q[s] <= d_in;
      end
    end
  end

  assign quotient_o  = q_q[DivStages-1];
  assign remainder_o = r_q[DivStages-1];

endmodule

>>> dv/tb_rv32im_decode_execute.sv
// Testbench for rv32im_decode_execute: drives instruction requests, predicts results
// with an in-bench decoder/executor and checks them in order through a scoreboard.
// Depends on rvde_pkg, rvde_if and the DUT.
`timescale 1ns / 1ps

module tb_rv32im_decode_execute;
  import rvde_pkg::*;

  typedef struct packed {
    logic [4:0]  dest_reg;
    logic        dest_write;
    logic [31:0] dest_value;
    logic [31:0] next_pc;
    logic [2:0]  load_kind;
    logic [1:0]  store_size;
    logic [31:0] mem_address;
    logic [31:0] store_value;
    logic        unknown;
  } exec_res_t;

  localparam int CycleLimit = 400000;

  function automatic logic [31:0] alu_base(logic [2:0] f3, logic alt, logic [31:0] a,
                                           logic [31:0] b);
    logic [4:0] sh;
    sh = b[4:0];
    case (f3)
      3'd0: return alt ? a - b : a + b;
      3'd1: return a << sh;
      3'd2: return {31'd0, $signed(a) < $signed(b)};
      3'd3: return {31'd0, a < b};
      3'd4: return a ^ b;
      3'd5: return alt ? $unsigned($signed(a) >>> sh) : a >> sh;
      3'd6: return a | b;
      default: return a & b;
    endcase
  endfunction

  function automatic logic [31:0] alu_muldiv(logic [2:0] f3, logic [31:0] a, logic [31:0] b);
    logic signed [63:0] sa, sb;
    logic [63:0] p;
    logic [31:0] ma, mb, q;
    sa = {{32{a[31]}}, a};
    sb = {{32{b[31]}}, b};
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    case (f3)
      3'd0: return a * b;
      3'd1: begin p = sa * sb; return p[63:32]; end
      3'd2: begin p = sa * {32'd0, b}; return p[63:32]; end
      3'd3: begin p = {32'd0, a} * {32'd0, b}; return p[63:32]; end
      3'd4: begin
        if (b == 0) return '1;
        q = ma / mb;
        return (a[31] != b[31]) ? -q : q;
      end
      3'd5: return (b == 0) ? '1 : a / b;
      3'd6: begin
        if (b == 0) return a;
        q = ma % mb;
        return a[31] ? -q : q;
      end
      default: return (b == 0) ? a : a % b;
    endcase
  endfunction

  function automatic exec_res_t execute_instr(logic [31:0] ins, logic [31:0] pc,
                                              logic [31:0] a, logic [31:0] b);
    exec_res_t r;
    logic [6:0] opc, f7;
    logic [2:0] f3;
    logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j, seq, val, npc, addr, sv;
    logic bad, wr, take;
    logic [2:0] lk;
    logic [1:0] ss;
    opc = ins[6:0]; f3 = ins[14:12]; f7 = ins[31:25];
    imm_i = {{20{ins[31]}}, ins[31:20]};
    imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    imm_u = {ins[31:12], 12'd0};
    imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    seq = pc + 4;
    bad = 0; wr = 0; take = 0; val = 0; npc = seq; lk = LK_NONE; ss = SS_NONE;
    addr = 0; sv = 0;
    case (opc)
      OPC_LOAD:
        if (f3 == 3 || f3 > 5) bad = 1;
        else begin
          wr = 1; lk = (f3 < 3) ? f3 + 3'd1 : f3; addr = a + imm_i;
        end
      OPC_STORE:
        if (f3 > 2) bad = 1;
        else begin
          ss = f3[1:0] + 2'd1; addr = a + imm_s; sv = b;
        end
      OPC_OPIMM, OPC_OPIMM32:
        if (opc == OPC_OPIMM32 && f3 != 0 && f3 != 1 && f3 != 5) bad = 1;
        else if (f3 == 1 && f7 != F7_BASE) bad = 1;
        else if (f3 == 5 && f7 != F7_BASE && f7 != F7_ALT) bad = 1;
        else begin
          wr = 1; val = alu_base(f3, f3 == 5 && f7 == F7_ALT, a, imm_i);
        end
      OPC_OP, OPC_OP32:
        if (f7 == F7_MULDIV) begin
          if (opc == OPC_OP32 && f3 >= 1 && f3 <= 3) bad = 1;
          else begin wr = 1; val = alu_muldiv(f3, a, b); end
        end else if (f7 == F7_BASE || f7 == F7_ALT) begin
          if (f7 == F7_ALT && f3 != 0 && f3 != 5) bad = 1;
          else if (opc == OPC_OP32 && f3 != 0 && f3 != 1 && f3 != 5) bad = 1;
          else begin wr = 1; val = alu_base(f3, f7 == F7_ALT, a, b); end
        end else bad = 1;
      OPC_AUIPC: begin wr = 1; val = pc + imm_u; end
      OPC_LUI: begin wr = 1; val = imm_u; end
      OPC_JAL: begin wr = 1; val = seq; npc = pc + imm_j; end
      OPC_JALR:
        if (f3 != 0) bad = 1;
        else begin
          wr = 1; val = seq; npc = (a + imm_i) & ~32'd1;
        end
      OPC_BRANCH: begin
        case (f3)
          3'd0: take = a == b;
          3'd1: take = a != b;
          3'd4: take = $signed(a) < $signed(b);
          3'd5: take = $signed(a) >= $signed(b);
          3'd6: take = a < b;
          3'd7: take = a >= b;
          default: bad = 1;
        endcase
        if (take) npc = pc + imm_b;
      end
      default: bad = 1;
    endcase
    if (bad) begin
      wr = 0; val = 0; npc = seq; lk = LK_NONE; ss = SS_NONE; addr = 0; sv = 0;
    end
    r.dest_reg = wr ? ins[11:7] : 5'd0;
    r.dest_write = wr;
    r.dest_value = (lk != LK_NONE) ? 32'd0 : val;
    r.next_pc = npc;
    r.load_kind = lk;
    r.store_size = ss;
    r.mem_address = addr;
    r.store_value = sv;
    r.unknown = bad;
    return r;
  endfunction

  class exec_scoreboard;
    exec_res_t pending[$];
    int errors;

    function void note_request(logic [31:0] ins, logic [31:0] pc, logic [31:0] a,
                               logic [31:0] b);
      pending.push_back(execute_instr(ins, pc, a, b));
    endfunction

    function void check_result(exec_res_t got);
      exec_res_t e;
      if (pending.size() == 0) begin
        $error("result with no request pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.dest_reg !== e.dest_reg) begin
        $error("dest_reg exp %0d got %0d", e.dest_reg, got.dest_reg); errors++;
      end
      if (got.dest_write !== e.dest_write) begin
        $error("dest_write exp %0d got %0d", e.dest_write, got.dest_write); errors++;
      end
      if (got.dest_value !== e.dest_value) begin
        $error("dest_value exp %h got %h", e.dest_value, got.dest_value); errors++;
      end
      if (got.next_pc !== e.next_pc) begin
        $error("next_pc exp %h got %h", e.next_pc, got.next_pc); errors++;
      end
      if (got.load_kind !== e.load_kind) begin
        $error("load_kind exp %0d got %0d", e.load_kind, got.load_kind); errors++;
      end
      if (got.store_size !== e.store_size) begin
        $error("store_size exp %0d got %0d", e.store_size, got.store_size); errors++;
      end
      if (got.mem_address !== e.mem_address) begin
        $error("mem_address exp %h got %h", e.mem_address, got.mem_address); errors++;
      end
      if (got.store_value !== e.store_value) begin
        $error("store_value exp %h got %h", e.store_value, got.store_value); errors++;
      end
      if (got.unknown !== e.unknown) begin
        $error("unknown_instruction exp %0d got %0d", e.unknown, got.unknown); errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  rvde_in_if req_if();
  rvde_out_if rsp_if();

  rv32im_decode_execute DUT (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_if.sink),
                             .rsp_o(rsp_if.source));

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  exec_scoreboard sb = new();
  int src_idle_pct, snk_idle_pct;
  int cycles;
  bit done;

  initial begin
    req_if.valid = 0;
    req_if.instruction = 0;
    req_if.pc = 0;
    req_if.rs1_value = 0;
    req_if.rs2_value = 0;
    rsp_if.ready = 0;
  end

  // receiver: random stalls, checks every accepted result
  always @(posedge clk_i) begin
    exec_res_t got;
    if (rsp_if.valid && rsp_if.ready) begin
      got.dest_reg = rsp_if.dest_reg;
      got.dest_write = rsp_if.dest_write;
      got.dest_value = rsp_if.dest_value;
      got.next_pc = rsp_if.next_pc;
      got.load_kind = rsp_if.load_kind;
      got.store_size = rsp_if.store_size;
      got.mem_address = rsp_if.mem_address;
      got.store_value = rsp_if.store_value;
      got.unknown = rsp_if.unknown_instruction;
      sb.check_result(got);
    end
    if (rst_ni) rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // sends one request; valid stays high across back-to-back requests
  task automatic send_request(logic [31:0] ins, logic [31:0] pc, logic [31:0] a,
                              logic [31:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 0;
      @(posedge clk_i);
    end
    req_if.valid <= 1;
    req_if.instruction <= ins;
    req_if.pc <= pc;
    req_if.rs1_value <= a;
    req_if.rs2_value <= b;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_request(ins, pc, a, b);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(16);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_instr();
    logic [6:0] opcs[11];
    logic [31:0] ins;
    opcs = '{OPC_LOAD, OPC_OPIMM, OPC_OPIMM32, OPC_JALR, OPC_AUIPC, OPC_LUI,
             OPC_STORE, OPC_OP, OPC_OP32, OPC_BRANCH, OPC_JAL};
    ins = $urandom;
    if ($urandom_range(9) == 0) return ins;  // noise, mostly unknown opcodes
    ins[6:0] = opcs[$urandom_range(10)];
    if (ins[6:0] == OPC_OP || ins[6:0] == OPC_OP32 ||
        (ins[13:12] == 2'b01 && (ins[6:0] == OPC_OPIMM || ins[6:0] == OPC_OPIMM32))) begin
      case ($urandom_range(7))
        0, 1, 2: ins[31:25] = F7_BASE;
        3, 4: ins[31:25] = F7_ALT;
        5, 6: ins[31:25] = F7_MULDIV;
        default: ;
      endcase
    end
    return ins;
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++)
      send_request(rand_instr(), $urandom, rand_operand(), rand_operand());
  endtask

  initial begin
    logic [6:0] opcs[11];
    opcs = '{OPC_LOAD, OPC_OPIMM, OPC_OPIMM32, OPC_JALR, OPC_AUIPC, OPC_LUI,
             OPC_STORE, OPC_OP, OPC_OP32, OPC_BRANCH, OPC_JAL};
    cycles = 0;
    src_idle_pct = 15;
    snk_idle_pct = 86;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: div/rem corner cases, all-ones / all-zeros fields, bad encodings
    send_request({F7_MULDIV, 5'd2, 5'd1, 3'd4, 5'd3, OPC_OP}, 0, 32'h8000_0000, '1);
    send_request({F7_MULDIV, 5'd2, 5'd1, 3'd6, 5'd3, OPC_OP}, 0, 32'h8000_0000, '1);
    send_request({F7_MULDIV, 5'd2, 5'd1, 3'd4, 5'd3, OPC_OP}, 0, 32'd7, 0);
    send_request({F7_MULDIV, 5'd2, 5'd1, 3'd5, 5'd3, OPC_OP32}, 0, 32'd7, 0);
    send_request({F7_MULDIV, 5'd2, 5'd1, 3'd6, 5'd3, OPC_OP}, 0, -32'sd7, 0);
    send_request({F7_MULDIV, 5'd2, 5'd1, 3'd7, 5'd3, OPC_OP}, 0, 32'd9, 0);
    send_request({F7_MULDIV, 5'd2, 5'd1, 3'd3, 5'd3, OPC_OP}, 0, '1, '1);
    send_request({F7_ALT, 5'd2, 5'd1, 3'd5, 5'd3, OPC_OP}, 0, 32'h8000_0000, 32'hFFFF_FFE3);
    send_request({F7_ALT, 5'd31, 5'd1, 3'd5, 5'd3, OPC_OPIMM}, 0, 32'h8000_0000, 0);
    send_request({12'hFFF, 5'd1, 3'd0, 5'd31, OPC_JALR}, '1, 32'h1234_5679, 0);
    send_request({20'hFFFFF, 5'd31, OPC_JAL}, 32'hFFFF_FFFC, 0, 0);
    send_request('1, '1, '1, '1);
    send_request('0, '0, '0, '0);
    send_request({7'h7F, 5'd2, 5'd1, 3'd5, 5'd0, OPC_BRANCH}, 32'h100, -32'sd1, 32'd1);
    send_request({7'h7F, 5'd2, 5'd1, 3'd2, 5'd0, OPC_BRANCH}, 32'h100, 0, 0);
    send_request({12'h800, 5'd1, 3'd6, 5'd4, OPC_LOAD}, 0, 32'h10, 0);
    send_request({12'h7FF, 5'd1, 3'd5, 5'd4, OPC_LOAD}, 0, '1, 0);
    send_request({7'h40, 5'd2, 5'd1, 3'd2, 5'd4, OPC_STORE}, 0, 32'h10, 32'hDEAD_BEEF);
    send_request({7'h00, 5'd2, 5'd1, 3'd3, 5'd4, OPC_STORE}, 0, 32'h10, 32'h1);
    send_request({F7_BASE, 5'd2, 5'd1, 3'd2, 5'd3, OPC_OP32}, 0, 32'd1, 32'd2);
    send_request({7'h02, 5'd2, 5'd1, 3'd0, 5'd3, OPC_OP}, 0, 32'd1, 32'd2);
    foreach (opcs[i]) send_request({$urandom} & 32'hFFFF_FF80 | opcs[i], $urandom,
                                   $urandom, $urandom);
    run_random(230);
    src_idle_pct = 86;
    snk_idle_pct = 15;
    run_random(230);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_random(240);
    req_if.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
